### rtl/mspr_pkg.sv
// Shared types and constants for the MSP v1 frame receiver.
`default_nettype none

package mspr_pkg;

  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] PROTO_BYTE = 8'h4D;
  localparam logic [7:0] DIR_RESET  = 8'h3C;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_DIR = 2'd1;
  localparam logic [1:0] ST_BAD_SUM = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_PROTO   = 3'd1,
    PH_DIR     = 3'd2,
    PH_SIZE    = 3'd3,
    PH_CMD     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CSUM    = 3'd6
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] command;
    logic [7:0] byte_index;
    logic [7:0] payload_byte;
    logic [7:0] frame_length;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

### rtl/mspr_parse.sv
// Frame parser: phase state machine, header capture and running checksum.
`default_nettype none

module mspr_parse (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              take,
  input  wire [7:0]        rx_byte,
  input  wire              cfg_we,
  input  wire [7:0]        cfg_dir,
  output logic             res_valid,
  output mspr_pkg::result_t res
);
  import mspr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] exp_dir_r;
  logic [7:0] dir_seen_r, dir_seen_nxt;
  logic [7:0] size_r, size_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] taken_r, taken_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] taken_inc;

  assign taken_inc = taken_r + 8'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) phase_nxt = PH_PROTO;
      end
      PH_PROTO: begin
        if (rx_byte == PROTO_BYTE) phase_nxt = PH_DIR;
        else if (rx_byte != START_BYTE) phase_nxt = PH_HUNT;
      end
      PH_DIR:  phase_nxt = PH_SIZE;
      PH_SIZE: phase_nxt = PH_CMD;
      PH_CMD:  phase_nxt = (size_r == 8'd0) ? PH_CSUM : PH_PAYLOAD;
      PH_PAYLOAD: begin
        if (taken_inc == size_r) phase_nxt = PH_CSUM;
      end
      PH_CSUM: phase_nxt = PH_HUNT;
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // datapath and result
  always_comb begin
    dir_seen_nxt = dir_seen_r;
    size_nxt     = size_r;
    cmd_nxt      = cmd_r;
    taken_nxt    = taken_r;
    xor_nxt      = xor_r;
    res_valid    = 1'b0;
    res          = '0;
    res.command  = cmd_r;
    case (phase_r)
      PH_DIR:  dir_seen_nxt = rx_byte;
      PH_SIZE: begin
        size_nxt = rx_byte;
        xor_nxt  = rx_byte;
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        taken_nxt = 8'd0;
      end
      PH_PAYLOAD: begin
        xor_nxt          = xor_r ^ rx_byte;
        taken_nxt        = taken_inc;
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.byte_index   = taken_r;
        res.payload_byte = rx_byte;
      end
      PH_CSUM: begin
        res_valid        = 1'b1;
        res.kind         = KIND_END;
        res.frame_length = size_r;
        if (dir_seen_r != exp_dir_r) res.status = ST_BAD_DIR;
        else if (xor_r != rx_byte)   res.status = ST_BAD_SUM;
        else                         res.status = ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      exp_dir_r  <= DIR_RESET;
      dir_seen_r <= 8'd0;
      size_r     <= 8'd0;
      cmd_r      <= 8'd0;
      taken_r    <= 8'd0;
      xor_r      <= 8'd0;
    end else begin
      if (cfg_we) exp_dir_r <= cfg_dir;
      if (take) begin
        phase_r    <= phase_nxt;
        dir_seen_r <= dir_seen_nxt;
        size_r     <= size_nxt;
        cmd_r      <= cmd_nxt;
        taken_r    <= taken_nxt;
        xor_r      <= xor_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mspr_out_reg.sv
// Result register between the parser and the output channel.
`default_nettype none

module mspr_out_reg (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               ld_valid,
  input  mspr_pkg::result_t ld_res,
  input  wire               out_stall,
  output logic              busy,
  output logic              out_valid,
  output mspr_pkg::result_t out_res
);
  import mspr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // full and not draining: hold the upstream side
  assign busy      = valid_r & out_stall;
  assign valid_nxt = busy ? 1'b1 : ld_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && ld_valid) res_r <= ld_res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

### rtl/msp_v1_frame_receiver.sv
// Top level of the MSP v1 frame receiver.
`default_nettype none

// Takes one serial byte per transfer and deframes MSP v1 frames ('$', 'M',
// direction, size, command, payload, XOR checksum). Each payload byte comes
// out as a transfer of kind 0 tagged with command and index; the checksum
// byte yields a kind 1 transfer with length and status (0 accepted, 1 wrong
// direction, 2 bad checksum). One byte is taken every cycle unless in_stall is
// high: parser state updates in the cycle a byte is taken and its result lands
// in a single output register, shown the cycle after; in_stall is raised only
// while that register holds a result that the output side is stalling.
// cfg_expected_direction (reset '<') is always ready and should be written
// only while no frame is in progress.
module msp_v1_frame_receiver (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  in_rx_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_kind,
  output logic [7:0] out_command,
  output logic [7:0] out_byte_index,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_frame_length,
  output logic [1:0] out_status,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [7:0]  cfg_expected_direction
);
  import mspr_pkg::*;

  logic    busy;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_stall  = busy;
  assign take      = in_valid & ~busy;
  assign cfg_ready = 1'b1;

  mspr_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_valid),
    .cfg_dir   (cfg_expected_direction),
    .res_valid (res_valid),
    .res       (res)
  );

  mspr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (take & res_valid),
    .ld_res    (res),
    .out_stall (out_stall),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_command      = out_res.command;
  assign out_byte_index   = out_res.byte_index;
  assign out_payload_byte = out_res.payload_byte;
  assign out_frame_length = out_res.frame_length;
  assign out_status       = out_res.status;

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the MSP v1 frame receiver: random byte streams, random stalls.
module testbench;
  import mspr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_BYTES = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_command;
  logic [7:0] out_byte_index;
  logic [7:0] out_payload_byte;
  logic [7:0] out_frame_length;
  logic [1:0] out_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_expected_direction = 8'h00;

  // Parser state as predicted from the accepted bytes
  phase_t     parse_phase = PH_HUNT;
  logic [7:0] dir_seen = 8'h00;
  logic [7:0] size_seen = 8'h00;
  logic [7:0] cmd_seen = 8'h00;
  logic [7:0] idx_taken = 8'h00;
  logic [7:0] xor_acc = 8'h00;
  logic [7:0] dir_want = DIR_RESET;

  logic [7:0]  rx_stream [$];
  result_t     frame_events_due [$];
  result_t     seen_result;
  result_t     due_result;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned cycle_count = 0;
  int unsigned fault_count = 0;

  msp_v1_frame_receiver dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_kind               (out_kind),
    .out_command            (out_command),
    .out_byte_index         (out_byte_index),
    .out_payload_byte       (out_payload_byte),
    .out_frame_length       (out_frame_length),
    .out_status             (out_status),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_expected_direction (cfg_expected_direction)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the parser by one byte and queue the result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    result_t due;
    due = '0;
    case (parse_phase)
      PH_HUNT: begin
        if (b == START_BYTE) parse_phase = PH_PROTO;
      end
      PH_PROTO: begin
        if (b == PROTO_BYTE) parse_phase = PH_DIR;
        else if (b != START_BYTE) parse_phase = PH_HUNT;
      end
      PH_DIR: begin
        dir_seen = b;
        parse_phase = PH_SIZE;
      end
      PH_SIZE: begin
        size_seen = b;
        xor_acc = b;
        parse_phase = PH_CMD;
      end
      PH_CMD: begin
        cmd_seen = b;
        xor_acc = xor_acc ^ b;
        idx_taken = 8'h00;
        parse_phase = (size_seen == 8'h00) ? PH_CSUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        xor_acc = xor_acc ^ b;
        due.kind = KIND_PAYLOAD;
        due.command = cmd_seen;
        due.byte_index = idx_taken;
        due.payload_byte = b;
        frame_events_due.push_back(due);
        idx_taken = idx_taken + 8'h01;
        if (idx_taken == size_seen) parse_phase = PH_CSUM;
      end
      PH_CSUM: begin
        due.kind = KIND_END;
        due.command = cmd_seen;
        due.frame_length = size_seen;
        // direction is checked ahead of the checksum
        if (dir_seen != dir_want) due.status = ST_BAD_DIR;
        else if (xor_acc != b) due.status = ST_BAD_SUM;
        else due.status = ST_OK;
        frame_events_due.push_back(due);
        parse_phase = PH_HUNT;
      end
      default: begin
        parse_phase = PH_HUNT;
      end
    endcase
  endtask

  // Mostly short gaps, a few long ones, none during a calm stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_left != 0 || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return START_BYTE;
    if (r < 15) return PROTO_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r == 0) return 8'hFF;
    if (r < 8) return 8'($urandom_range(20, 100));
    if (r < 40) return 8'($urandom_range(7, 19));
    return 8'($urandom_range(0, 6));
  endfunction

  function automatic logic [7:0] pick_dir();
    if ($urandom_range(0, 99) < 85) return dir_want;
    return 8'($urandom_range(0, 255));
  endfunction

  // Queue one frame, or only its first keep bytes when keep is nonzero.
  function automatic int unsigned push_frame(input logic [7:0] dir, input logic [7:0] size,
                                             input logic [7:0] cmd, input bit sum_ok,
                                             input int unsigned keep);
    logic [7:0]  frame_q [$];
    logic [7:0]  sum;
    logic [7:0]  pb;
    int unsigned i;
    int unsigned n;
    frame_q.push_back(START_BYTE);
    frame_q.push_back(PROTO_BYTE);
    frame_q.push_back(dir);
    frame_q.push_back(size);
    frame_q.push_back(cmd);
    sum = size ^ cmd;
    for (i = 0; i < size; i++) begin
      pb = pick_byte();
      frame_q.push_back(pb);
      sum = sum ^ pb;
    end
    if (!sum_ok) sum = sum ^ 8'($urandom_range(1, 255));
    frame_q.push_back(sum);
    n = (keep != 0 && keep < frame_q.size()) ? keep : frame_q.size();
    for (i = 0; i < n; i++) rx_stream.push_back(frame_q[i]);
    return n;
  endfunction

  task automatic random_traffic(input int unsigned budget);
    int unsigned used;
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    logic [7:0]  size;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(0, 99);
      size = pick_size();
      if (pick < 80) begin
        used += push_frame(pick_dir(), size, 8'($urandom_range(0, 255)),
                           $urandom_range(0, 99) < 85, 0);
      end else if (pick < 90) begin
        // line noise, heavy on start bytes
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          rx_stream.push_back(($urandom_range(0, 2) == 0) ? START_BYTE : pick_byte());
        end
        used += n;
      end else begin
        // truncated frame: the following bytes land inside it
        used += push_frame(pick_dir(), size, 8'($urandom_range(0, 255)), 1'b1,
                           $urandom_range(1, 5 + size));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (rx_stream.size() != 0 || in_valid || frame_events_due.size() != 0);
  endtask

  // Hold the sender until all results are in and the parser is back to hunting.
  task automatic settle();
    wait_drained();
    while (parse_phase != PH_HUNT) begin
      rx_stream.push_back(8'h00);
      wait_drained();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_direction(input logic [7:0] value);
    cfg_expected_direction <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    dir_want = value;
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_stream.pop_front();
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_result = {out_kind, out_command, out_byte_index, out_payload_byte,
                       out_frame_length, out_status};
        if (frame_events_due.size() == 0) begin
          $display("%0t: unexpected result kind=%0d cmd=%02h idx=%0d byte=%02h len=%0d st=%0d",
                   $time, seen_result.kind, seen_result.command, seen_result.byte_index,
                   seen_result.payload_byte, seen_result.frame_length, seen_result.status);
          fault_count++;
        end else begin
          due_result = frame_events_due.pop_front();
          if (seen_result !== due_result) begin
            $display("%0t: mismatch expected kind=%0d cmd=%02h idx=%0d byte=%02h len=%0d st=%0d",
                     $time, due_result.kind, due_result.command, due_result.byte_index,
                     due_result.payload_byte, due_result.frame_length, due_result.status);
            $display("%0t:          actual kind=%0d cmd=%02h idx=%0d byte=%02h len=%0d st=%0d",
                     $time, seen_result.kind, seen_result.command, seen_result.byte_index,
                     seen_result.payload_byte, seen_result.frame_length, seen_result.status);
            fault_count++;
          end
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Calm stretches and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (calm_left != 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 299) == 0) calm_left <= $urandom_range(50, 250);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [7:0]  opening [24];
    logic [7:0]  plan [4];
    int unsigned k;
    // start byte twice then an empty accepted frame; start byte then junk;
    // wrong direction with bad checksum and a start byte in the payload;
    // bad checksum alone
    opening = '{START_BYTE, START_BYTE, PROTO_BYTE, DIR_RESET, 8'h00, 8'hFF, 8'hFF,
                START_BYTE, 8'h41,
                START_BYTE, PROTO_BYTE, 8'h3E, 8'h02, 8'h00, START_BYTE, 8'hFF, 8'h00,
                START_BYTE, PROTO_BYTE, DIR_RESET, 8'h01, 8'h80, PROTO_BYTE, 8'h33};
    plan = '{8'h00, 8'hFF, 8'h00, DIR_RESET};
    plan[2] = 8'($urandom_range(1, 254));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < 24; k++) rx_stream.push_back(opening[k]);
    random_traffic(PHASE_BYTES);
    settle();
    for (k = 0; k < 4; k++) begin
      write_direction(plan[k]);
      if (k == 0) void'(push_frame(dir_want, 8'hFF, 8'($urandom_range(0, 255)), 1'b1, 0));
      random_traffic(PHASE_BYTES);
      settle();
    end
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
